### hw/rtl/iib_pkg.sv
// iib_pkg: shared types for the indexed insert buffer.
// Action and status codes, and the control word broadcast to the cell row.
// No dependencies.
package iib_pkg;

    typedef enum logic [2:0] {
        ACT_PUSH   = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_POP    = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_READ   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic wr_en;  // write a word this cycle
        logic ins;    // cells above the write position take their neighbor
    } cell_ctl_t;

endpackage

### hw/rtl/iib_req_if.sv
// iib_req_if: request channel of the indexed insert buffer.
// Valid/ready handshake carrying action, index and value. No dependencies.
interface iib_req_if #(
    parameter int IDX_W  = 9,
    parameter int DATA_W = 32
);
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] value;

    modport source (output valid, output action, output index, output value, input ready);
    modport sink   (input valid, input action, input index, input value, output ready);
endinterface

### hw/rtl/iib_rsp_if.sv
// iib_rsp_if: result channel of the indexed insert buffer.
// Valid/ready handshake carrying read_data, status and count. No dependencies.
interface iib_rsp_if #(
    parameter int IDX_W  = 9,
    parameter int DATA_W = 32
);
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic [1:0]        status;
    logic [IDX_W-1:0]  count;

    modport source (output valid, output read_data, output status, output count, input ready);
    modport sink   (input valid, input read_data, input status, input count, output ready);
endinterface

### hw/rtl/iib_cell.sv
// iib_cell: one storage cell of the buffer row, holding the entry at POS.
// Loads the broadcast word, or its lower neighbor's word on insert. Uses iib_pkg.
module iib_cell
    import iib_pkg::*;
#(
    parameter int DATA_W = 32,
    parameter int IDX_W  = 9,
    parameter int POS    = 0
) (
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic [IDX_W-1:0]  wr_pos,
    input  logic [DATA_W-1:0] value,
    input  logic [DATA_W-1:0] prev_data,
    input  logic [IDX_W-1:0]  rd_idx,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] rd_data
);

    localparam logic [IDX_W-1:0] MyPos = IDX_W'(POS);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.wr_en && (wr_pos == MyPos))
        begin
            data_next = value;
        end
        else if (ctl.wr_en && ctl.ins && (MyPos > wr_pos))
        begin
            data_next = prev_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (rd_idx == MyPos) ? data_reg : '0;

endmodule

### hw/rtl/indexed_insert_buffer.sv
// indexed_insert_buffer: ordered buffer of DEPTH words held in a row of cells.
// Results pass through the s1 and out registers; the read OR tree is registered in s1.
// Throughput: one request per cycle unless rsp.ready stalls it; insert shifts every cell above the index together.
// Reset (rst_n, async, active low) clears the count and pipeline valids;
// cell contents are not reset and are only read below the count.
module indexed_insert_buffer
    import iib_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    iib_req_if.sink     req,
    iib_rsp_if.source   rsp
);

    localparam int IDX_W = $clog2(DEPTH + 1);
    localparam int GRP   = 16;
    localparam int NGRP  = (DEPTH + GRP - 1) / GRP;
    localparam logic [IDX_W-1:0] Full = IDX_W'(DEPTH);

    logic              fire;
    action_t           act;
    cell_ctl_t         ctl;
    logic [IDX_W-1:0]  wr_pos;
    status_t           status_d;
    logic [IDX_W-1:0]  count_next;
    logic              rd_ok_d;

    logic [IDX_W-1:0]  count_reg;

    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] cell_rd   [DEPTH];
    logic [DATA_W-1:0] grp_or    [NGRP];

    logic              s1_valid_reg;
    logic [DATA_W-1:0] s1_grp_reg [NGRP];
    logic              s1_rd_ok_reg;
    status_t           s1_status_reg;
    logic [IDX_W-1:0]  s1_count_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    status_t           out_status_reg;
    logic [IDX_W-1:0]  out_count_reg;

    logic              s2_take;
    logic [DATA_W-1:0] final_or;

    assign s2_take   = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s2_take;
    assign fire      = req.valid && req.ready;
    assign act       = action_t'(req.action);

    always_comb
    begin
        ctl        = '0;
        wr_pos     = count_reg;
        status_d   = ST_OK;
        count_next = count_reg;
        rd_ok_d    = 1'b0;
        unique case (act)
            ACT_PUSH:
            begin
                if (count_reg >= Full)
                begin
                    status_d = ST_FULL;
                end
                else
                begin
                    ctl.wr_en  = 1'b1;
                    count_next = count_reg + IDX_W'(1);
                end
            end
            ACT_INSERT:
            begin
                if (req.index > count_reg)
                begin
                    status_d = ST_RANGE;
                end
                else if (count_reg >= Full)
                begin
                    status_d = ST_FULL;
                end
                else
                begin
                    ctl.wr_en  = 1'b1;
                    ctl.ins    = 1'b1;
                    wr_pos     = req.index;
                    count_next = count_reg + IDX_W'(1);
                end
            end
            ACT_POP:
            begin
                if (count_reg != '0)
                begin
                    count_next = count_reg - IDX_W'(1);
                end
            end
            ACT_CLEAR:
            begin
                count_next = '0;
            end
            ACT_READ:
            begin
                if (req.index >= count_reg)
                begin
                    status_d = ST_RANGE;
                end
                else
                begin
                    rd_ok_d = 1'b1;
                end
            end
            default:
            begin
                status_d = ST_OK;
            end
        endcase
        ctl.wr_en = ctl.wr_en && fire;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            iib_cell #(
                .DATA_W (DATA_W),
                .IDX_W  (IDX_W),
                .POS    (i)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .wr_pos    (wr_pos),
                .value     (req.value),
                .prev_data ({DATA_W{1'b0}}),
                .rd_idx    (req.index),
                .data      (cell_data[i]),
                .rd_data   (cell_rd[i])
            );
        end
        else
        begin : g_rest
            iib_cell #(
                .DATA_W (DATA_W),
                .IDX_W  (IDX_W),
                .POS    (i)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .wr_pos    (wr_pos),
                .value     (req.value),
                .prev_data (cell_data[i-1]),
                .rd_idx    (req.index),
                .data      (cell_data[i]),
                .rd_data   (cell_rd[i])
            );
        end
    end

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_or[g] = '0;
            for (int k = 0; k < GRP; k++)
            begin
                if (g * GRP + k < DEPTH)
                begin
                    grp_or[g] = grp_or[g] | cell_rd[g * GRP + k];
                end
            end
        end
    end

    always_comb
    begin
        final_or = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            final_or = final_or | s1_grp_reg[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg <= count_next;
            end
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_take)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_grp_reg    <= grp_or;
            s1_rd_ok_reg  <= rd_ok_d;
            s1_status_reg <= status_d;
            s1_count_reg  <= count_next;
        end
        if (s1_valid_reg && s2_take)
        begin
            out_data_reg   <= s1_rd_ok_reg ? final_or : '0;
            out_status_reg <= s1_status_reg;
            out_count_reg  <= s1_count_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.count     = out_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Full)
        else $error("count above capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_FULL)) |-> (rsp.count == Full))
        else $error("full status without full count");

    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.read_data == '0))
        else $error("read data on failed request");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (act == ACT_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty buffer");
`endif

endmodule

### test/indexed_insert_buffer_tb.sv
// indexed_insert_buffer_tb: self-checking bench for the indexed insert buffer.
// A queue-fed driver, an in-bench buffer predictor and a result monitor.
// Depends on iib_pkg, iib_req_if, iib_rsp_if and indexed_insert_buffer.
`timescale 1ns / 1ps

module indexed_insert_buffer_tb;
    import iib_pkg::*;

    localparam int DEPTH          = 256;
    localparam int DATA_W         = 32;
    localparam int IDX_W          = 9;
    localparam int REQUEST_TARGET = 850;
    localparam int STALL_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 8;

    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]        action;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] value;
    } buf_request_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        status_t           status;
        logic [IDX_W-1:0]  count;
    } buf_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    buf_request_t drv_req   = '0;
    logic         drv_valid = 1'b0;
    logic         rsp_rdy   = 1'b0;

    buf_request_t pending_requests[$];
    buf_result_t  expected_results[$];

    logic [DATA_W-1:0] cells [DEPTH];
    int fill_level;
    int gen_count;
    int request_total;
    int requests_accepted;
    int results_seen;
    int mismatches;
    int stall_cycles;

    iib_req_if #(.IDX_W(IDX_W), .DATA_W(DATA_W)) req_if ();
    iib_rsp_if #(.IDX_W(IDX_W), .DATA_W(DATA_W)) rsp_if ();

    assign req_if.valid  = drv_valid;
    assign req_if.action = drv_req.action;
    assign req_if.index  = drv_req.index;
    assign req_if.value  = drv_req.value;
    assign rsp_if.ready  = rsp_rdy;

    indexed_insert_buffer #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #4 clk = ~clk;

    function automatic int idle_pct(input int done, input bit receiver);
        if (done < request_total / 3)
            return receiver ? 69 : 6;
        else if (done < (2 * request_total) / 3)
            return receiver ? 6 : 69;
        return 0;
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_request(input logic [2:0] act, input int idx, input logic [DATA_W-1:0] val);
        buf_request_t rq;
        rq.action = act;
        rq.index  = IDX_W'(idx);
        rq.value  = val;
        pending_requests = {pending_requests, rq};
        case (act)
            ACT_PUSH:   if (gen_count < DEPTH) gen_count++;
            ACT_INSERT: if (idx <= gen_count && gen_count < DEPTH) gen_count++;
            ACT_POP:    if (gen_count > 0) gen_count--;
            ACT_CLEAR:  gen_count = 0;
            default:    ;
        endcase
    endtask

    // buffer predictor: applies one accepted request and returns its result
    function automatic buf_result_t buffer_result(input buf_request_t rq);
        buf_result_t res;
        int          i;
        res.read_data = '0;
        res.status    = ST_OK;
        case (rq.action)
            ACT_PUSH:
                if (fill_level >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    cells[fill_level] = rq.value;
                    fill_level++;
                end
            ACT_INSERT:
                if (int'(rq.index) > fill_level)
                    res.status = ST_RANGE;
                else if (fill_level >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    for (i = fill_level; i > int'(rq.index); i--)
                        cells[i] = cells[i-1];
                    cells[rq.index] = rq.value;
                    fill_level++;
                end
            ACT_POP:
                if (fill_level > 0)
                    fill_level--;
            ACT_CLEAR:
                fill_level = 0;
            ACT_READ:
                if (int'(rq.index) >= fill_level)
                    res.status = ST_RANGE;
                else
                    res.read_data = cells[rq.index];
            default: ;
        endcase
        res.count = IDX_W'(fill_level);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : driver
        buf_request_t nxt;
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
        end
        else
        begin
            if (drv_valid && req_if.ready)
            begin
                expected_results = {expected_results, buffer_result(drv_req)};
                requests_accepted++;
            end
            if (!drv_valid || req_if.ready)
            begin
                if (pending_requests.size() > 0 &&
                    $urandom_range(0, 99) >= idle_pct(requests_accepted, 1'b0))
                begin
                    nxt = pending_requests.pop_front();
                    drv_req   <= nxt;
                    drv_valid <= 1'b1;
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        buf_result_t want;
        if (!rst_n)
        begin
            rsp_rdy <= 1'b0;
        end
        else
        begin
            if (rsp_if.valid && rsp_rdy)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_if.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %h, got %h", want.read_data,
                               rsp_if.read_data);
                        mismatches++;
                    end
                    if (rsp_if.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                        mismatches++;
                    end
                    if (rsp_if.count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, rsp_if.count);
                        mismatches++;
                    end
                end
            end
            rsp_rdy <= ($urandom_range(0, 99) >= idle_pct(results_seen, 1'b1));
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        int         pick;
        int         n;
        int         idx;
        int         a;
        bit         filled_once;
        logic [2:0] act;

        fill_level        = 0;
        gen_count         = 0;
        requests_accepted = 0;
        results_seen      = 0;
        mismatches        = 0;
        stall_cycles      = 0;
        filled_once       = 1'b0;

        // directed: empty-buffer corners, edge inserts, range errors, spare codes
        add_request(ACT_POP, 0, '0);
        add_request(ACT_READ, 0, '0);
        add_request(ACT_INSERT, 1, 32'h1234_5678);
        add_request(ACT_INSERT, 0, '1);
        add_request(ACT_PUSH, 0, '0);
        add_request(ACT_INSERT, 2, 32'hA5A5_A5A5);
        add_request(ACT_INSERT, 1, 32'h5A5A_5A5A);
        for (idx = 0; idx <= 4; idx++)
            add_request(ACT_READ, idx, '1);
        add_request(ACT_READ, DEPTH, '0);
        add_request(ACT_INSERT, DEPTH, '1);
        for (a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
            add_request(3'(a), DEPTH, '1);
        add_request(ACT_POP, DEPTH, '1);
        add_request(ACT_READ, 2, '0);
        add_request(ACT_CLEAR, DEPTH, '1);
        add_request(ACT_READ, 0, '0);
        add_request(ACT_PUSH, 0, random_word());

        while (pending_requests.size() < REQUEST_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (!filled_once && pending_requests.size() > 300)
                pick = 78;
            if (pick < 35)
            begin
                n = $urandom_range(1, 24);
                repeat (n)
                begin
                    if ($urandom_range(0, 2) == 0)
                        add_request(ACT_PUSH, $urandom_range(0, DEPTH), random_word());
                    else
                    begin
                        if (gen_count < DEPTH && $urandom_range(0, 9) == 0)
                            idx = $urandom_range(gen_count + 1, DEPTH);
                        else
                            idx = $urandom_range(0, gen_count);
                        add_request(ACT_INSERT, idx, random_word());
                    end
                end
            end
            else if (pick < 60)
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                begin
                    if (gen_count > 0 && $urandom_range(0, 4) != 0)
                        idx = $urandom_range(0, gen_count - 1);
                    else
                        idx = $urandom_range(gen_count, DEPTH);
                    add_request(ACT_READ, idx, random_word());
                end
            end
            else if (pick < 72)
            begin
                repeat ($urandom_range(1, 6))
                    add_request(ACT_POP, $urandom_range(0, DEPTH), random_word());
            end
            else if (pick < 76)
            begin
                add_request(ACT_CLEAR, $urandom_range(0, DEPTH), random_word());
            end
            else if (pick < 79)
            begin
                // fill to capacity, then hit the full case and the top entry
                filled_once = 1'b1;
                while (gen_count < DEPTH)
                begin
                    if ($urandom_range(0, 1) == 0)
                        add_request(ACT_PUSH, 0, random_word());
                    else
                        add_request(ACT_INSERT, $urandom_range(0, gen_count), random_word());
                end
                repeat ($urandom_range(2, 4))
                begin
                    act = ($urandom_range(0, 1) == 0) ? ACT_PUSH : ACT_INSERT;
                    add_request(act, $urandom_range(0, DEPTH), random_word());
                end
                add_request(ACT_READ, DEPTH - 1, '0);
                add_request(ACT_READ, DEPTH, '0);
                add_request(ACT_READ, 0, '0);
                add_request(ACT_POP, 0, '0);
                add_request(ACT_INSERT, $urandom_range(0, DEPTH - 1), random_word());
                add_request(ACT_READ, $urandom_range(0, DEPTH - 1), '0);
                if ($urandom_range(0, 1) == 0)
                    add_request(ACT_CLEAR, 0, '0);
            end
            else
            begin
                act = 3'($urandom_range(0, 7));
                add_request(act, $urandom_range(0, DEPTH), random_word());
            end
        end
        request_total = pending_requests.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_accepted < request_total || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
